// ===== hw/rtl/tremolo_gain_peak_guard_assert.svh =====
// Assertion macros for the tremolo gain and peak guard block.
// Included by the RTL files that carry concurrent assertions; needs no package.
`ifndef TREMOLO_GAIN_PEAK_GUARD_ASSERT_SVH
`define TREMOLO_GAIN_PEAK_GUARD_ASSERT_SVH
`ifndef ASSERT_OFF
`define TGPG_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TGPG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TGPG_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define TGPG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tgpg_pkg.sv =====
// Shared constants, codes and types of the tremolo gain and peak guard block.
// Used by every RTL file of the block; depends on nothing.
`default_nettype none

package tgpg_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF      = 24;

    localparam int PHASE_W        = 32;
    localparam int ANGLE_BITS     = 16;

    localparam int Q15_W          = 16;
    localparam int Q15_FRAC       = 15;
    localparam int OUT_GAIN_FRAC  = 14;
    localparam logic [Q15_W-1:0] Q15_ONE = 16'd32768;

    localparam logic [Q15_W-1:0] SIN_A = 16'd51472;
    localparam logic [Q15_W-1:0] SIN_B = 16'd21024;
    localparam logic [Q15_W-1:0] SIN_C = 16'd2320;

    localparam int TREM_DEPTH_W  = 16;
    localparam int PHASE_STEP_W  = 24;
    localparam int OUT_GAIN_W    = 16;
    localparam int PEAK_LIMIT_W  = 23;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [TREM_DEPTH_W-1:0] TREM_DEPTH_RST = 16'd16384;
    localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RST = 24'd447392;
    localparam logic [OUT_GAIN_W-1:0]   OUT_GAIN_RST   = 16'd16384;
    localparam logic [PEAK_LIMIT_W-1:0] PEAK_LIMIT_RST = 23'd8304721;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TREM_ENABLE = 3'd0,
        CFG_TREM_DEPTH  = 3'd1,
        CFG_PHASE_STEP  = 3'd2,
        CFG_OUT_GAIN    = 3'd3,
        CFG_PEAK_LIMIT  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        T_IDLE,
        T_LFO,
        T_MUL1,
        T_MUL2,
        T_DONE
    } t_top_state;

    typedef enum logic [2:0] {
        L_IDLE,
        L_DIV,
        L_T2,
        L_T2C,
        L_INNER,
        L_MID,
        L_SINE,
        L_GAIN
    } t_lfo_state;

    typedef struct packed {
        logic stage1_en;
        logic stage2_en;
    } t_lane_ctrl;

    typedef struct packed {
        logic clear;
        logic commit;
        logic mute;
        logic eob;
    } t_merge_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/tgpg_in_if.sv =====
// Input channel of the block: one stereo sample word with its block and clear flags.
// Depends on tgpg_pkg for the default sample width.
`default_nettype none

interface tgpg_in_if
    import tgpg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          end_of_block;
    logic                          clear_alarm;

    modport source (
        output valid, left_in, right_in, end_of_block, clear_alarm,
        input  ready
    );

    modport sink (
        input  valid, left_in, right_in, end_of_block, clear_alarm,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/tgpg_out_if.sv =====
// Output channel of the block: one processed stereo word and the mute flag.
// Depends on tgpg_pkg for the default sample width.
`default_nettype none

interface tgpg_out_if
    import tgpg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          muted;

    modport source (
        output valid, left_out, right_out, muted,
        input  ready
    );

    modport sink (
        input  valid, left_out, right_out, muted,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/tgpg_lfo.sv =====
// Sine LFO sequencer: angle division, quarter-wave polynomial and tremolo gain.
// One shared 16 x 16 multiplier, one step per cycle; depends on tgpg_pkg.
`default_nettype none

module tgpg_lfo
    import tgpg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PHASE_W-1:0] i_phase,
    input  logic [Q15_W-1:0]   i_depth,
    output logic               o_done,
    output logic [Q15_W-1:0]   o_gain
);

    localparam int RB    = $clog2(SINE_TABLE_DEPTH);
    localparam int DB    = RB + 1;
    localparam int IPW   = PHASE_W + DB;
    localparam int QSH   = 2 * RB;
    localparam int RCW   = ANGLE_BITS + RB + 2;
    localparam int QPW   = RB + RCW;
    localparam int PW    = 2 * Q15_W;
    localparam logic [DB-1:0] DEN = DB'(SINE_TABLE_DEPTH);
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (ANGLE_BITS + QSH)) + 64'(SINE_TABLE_DEPTH) - 64'd1)
        / 64'(SINE_TABLE_DEPTH);
    localparam logic [RCW-1:0] RECIP = RCW'(RECIP_FULL);

    t_lfo_state r_state, n_state;

    logic [RB-1:0]         r_idx;
    logic [ANGLE_BITS-1:0] r_quo;
    logic [Q15_W-1:0]      r_t;
    logic [Q15_W-1:0]      r_t2;
    logic                  r_neg;
    logic [PW-1:0]         r_prod;
    logic [Q15_W-1:0]      r_gain;
    logic                  r_done;

    logic [IPW-1:0]        w_idx_prod;
    logic [RB-1:0]         w_idx;
    logic [QPW-1:0]        w_quo_prod;
    logic [ANGLE_BITS-1:0] w_quo;
    logic [Q15_W-1:0]      w_t_raw;
    logic [Q15_W-1:0]      w_t;
    logic [Q15_W-1:0]      w_t2;
    logic [Q15_W-1:0]      w_inner;
    logic [Q15_W-1:0]      w_mid;
    logic [Q15_W-1:0]      w_s;
    logic [Q15_W:0]        w_lfo_sum;
    logic [Q15_W-1:0]      w_lfo;
    logic [Q15_W-1:0]      w_gain;
    logic [Q15_W-1:0]      w_mul_a;
    logic [Q15_W-1:0]      w_mul_b;
    logic [PW-1:0]         w_prod;

    assign w_idx_prod = IPW'(i_phase) * IPW'(DEN);
    assign w_idx      = w_idx_prod[PHASE_W +: RB];

    // Index times 2^16 over the table depth, by a rounded-up reciprocal that is exact for
    // every index below the depth.
    assign w_quo_prod = QPW'(r_idx) * QPW'(RECIP);
    assign w_quo      = w_quo_prod[QSH +: ANGLE_BITS];

    assign w_t_raw   = {1'b0, r_quo[ANGLE_BITS-3:0], 1'b0};
    assign w_t       = r_quo[ANGLE_BITS-2] ? Q15_W'(Q15_ONE - w_t_raw) : w_t_raw;
    assign w_t2      = r_prod[Q15_FRAC +: Q15_W];
    assign w_inner   = SIN_B - r_prod[Q15_FRAC +: Q15_W];
    assign w_mid     = SIN_A - r_prod[Q15_FRAC +: Q15_W];
    assign w_s       = r_prod[Q15_FRAC +: Q15_W];
    assign w_lfo_sum = r_neg ? ({1'b0, Q15_ONE} - {1'b0, w_s})
                             : ({1'b0, Q15_ONE} + {1'b0, w_s});
    assign w_lfo     = w_lfo_sum[Q15_W:1];
    assign w_gain    = Q15_ONE - i_depth + r_prod[Q15_FRAC +: Q15_W];

    always_comb begin
        case (r_state)
            L_T2: begin
                w_mul_a = w_t;
                w_mul_b = w_t;
            end
            L_T2C: begin
                w_mul_a = w_t2;
                w_mul_b = SIN_C;
            end
            L_INNER: begin
                w_mul_a = r_t2;
                w_mul_b = w_inner;
            end
            L_MID: begin
                w_mul_a = r_t;
                w_mul_b = w_mid;
            end
            L_SINE: begin
                w_mul_a = i_depth;
                w_mul_b = w_lfo;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = PW'(w_mul_a) * PW'(w_mul_b);

    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE:  if (i_start) n_state = L_DIV;
            L_DIV:   n_state = L_T2;
            L_T2:    n_state = L_T2C;
            L_T2C:   n_state = L_INNER;
            L_INNER: n_state = L_MID;
            L_MID:   n_state = L_SINE;
            L_SINE:  n_state = L_GAIN;
            L_GAIN:  n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == L_GAIN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_state == L_IDLE && i_start) begin
            r_idx <= w_idx;
        end
        if (r_state == L_DIV) begin
            r_quo <= w_quo;
        end
        if (r_state == L_T2) begin
            r_t   <= w_t;
            r_neg <= r_quo[ANGLE_BITS-1];
        end
        if (r_state == L_T2C) begin
            r_t2 <= w_t2;
        end
        if (r_state == L_GAIN) begin
            r_gain <= w_gain;
        end
    end

    assign o_done = r_done;
    assign o_gain = r_gain;

endmodule

`default_nettype wire

// ===== hw/rtl/tgpg_lane.sv =====
// One channel lane: tremolo gain, output gain, saturation and magnitude.
// Two registered multiply stages; depends on tgpg_pkg.
`default_nettype none

module tgpg_lane
    import tgpg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                          i_clk,
    input  t_lane_ctrl                    i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [Q15_W-1:0]              i_gain,
    input  logic [OUT_GAIN_W-1:0]         i_out_gain,
    output logic [SAMPLE_BITS-1:0]        o_sample,
    output logic [SAMPLE_BITS-1:0]        o_mag
);

    localparam int Y1W = SAMPLE_BITS + 2;
    localparam int P1W = SAMPLE_BITS + Q15_W + 1;
    localparam int P2W = Y1W + OUT_GAIN_W + 1;
    localparam int Y2W = P2W - OUT_GAIN_FRAC;

    logic signed [Y1W-1:0]  r_y1;
    logic [SAMPLE_BITS-1:0] r_y2;
    logic [SAMPLE_BITS-1:0] r_mag;

    logic signed [P1W-1:0]       w_p1;
    logic signed [P2W-1:0]       w_p2;
    logic [Y2W-1:0]              w_y2;
    logic [Y2W-SAMPLE_BITS:0]    w_hi;
    logic                        w_fits;
    logic [SAMPLE_BITS-1:0]      w_sat;
    logic [SAMPLE_BITS-1:0]      w_mag;

    assign w_p1 = P1W'(i_sample) * P1W'($signed({1'b0, i_gain}));
    assign w_p2 = P2W'(r_y1) * P2W'($signed({1'b0, i_out_gain}));
    assign w_y2 = w_p2[OUT_GAIN_FRAC +: Y2W];

    assign w_hi   = w_y2[Y2W-1:SAMPLE_BITS-1];
    assign w_fits = (&w_hi) | ~(|w_hi);
    assign w_sat  = w_fits ? w_y2[SAMPLE_BITS-1:0]
                  : (w_y2[Y2W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                 : {1'b0, {(SAMPLE_BITS-1){1'b1}}});
    assign w_mag  = w_sat[SAMPLE_BITS-1] ? SAMPLE_BITS'(-w_sat) : w_sat;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.stage1_en) begin
            r_y1 <= w_p1[Q15_FRAC +: Y1W];
        end
        if (i_ctrl.stage2_en) begin
            r_y2  <= w_sat;
            r_mag <= w_mag;
        end
    end

    assign o_sample = r_y2;
    assign o_mag    = r_mag;

endmodule

`default_nettype wire

// ===== hw/rtl/tgpg_peak_merge.sv =====
// Merging stage: combines the lane magnitudes into the block peak and latches the alarm.
// Holds the block peak and the alarm flag; depends on tgpg_pkg.
`default_nettype none

module tgpg_peak_merge
    import tgpg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_merge_cmd              i_cmd,
    input  logic [SAMPLE_BITS-1:0]  i_mag_l,
    input  logic [SAMPLE_BITS-1:0]  i_mag_r,
    input  logic [PEAK_LIMIT_W-1:0] i_peak_limit,
    output logic                    o_alarm
);

    localparam int CW = (SAMPLE_BITS > PEAK_LIMIT_W) ? SAMPLE_BITS : PEAK_LIMIT_W;

    logic [SAMPLE_BITS-1:0] r_peak;
    logic                   r_alarm;

    logic [SAMPLE_BITS-1:0] w_lane_max;
    logic [SAMPLE_BITS-1:0] w_new_peak;
    logic                   w_over;

    assign w_lane_max = (i_mag_l > i_mag_r) ? i_mag_l : i_mag_r;
    assign w_new_peak = (w_lane_max > r_peak) ? w_lane_max : r_peak;
    assign w_over     = CW'(w_new_peak) > CW'(i_peak_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_alarm <= 1'b0;
        end else if (i_cmd.clear) begin
            r_peak  <= '0;
            r_alarm <= 1'b0;
        end else if (i_cmd.commit) begin
            if (i_cmd.mute || i_cmd.eob) begin
                r_peak <= '0;
            end else begin
                r_peak <= w_new_peak;
            end
            if (!i_cmd.mute && i_cmd.eob && w_over) begin
                r_alarm <= 1'b1;
            end
        end
    end

    assign o_alarm = r_alarm;

endmodule

`default_nettype wire

// ===== hw/rtl/tremolo_gain_peak_guard.sv =====
// Top level of the stereo tremolo with output gain and block peak guard.
// Instantiates tgpg_lfo, two tgpg_lane, tgpg_peak_merge; uses tgpg_pkg and the channel interfaces.
//
// One stereo word is taken at a time and its result sits in an output register, so the next
// word is accepted while that result waits. With tremolo active, the sine sequencer runs
// first: an angle scaling followed by five steps through its single shared multiplier. With
// tremolo bypassed (disabled or zero depth) the sequencer is skipped, and while the mute alarm
// is latched the word goes straight to the commit state without the lane stages. Otherwise the
// left and right lanes run their two multiply stages side by side before the peak merge and
// phase update. A finished word waits to commit while the output register is still full.
// Configuration writes take effect at once and are meant for idle periods only.
`default_nettype none
`include "tremolo_gain_peak_guard_assert.svh"

module tremolo_gain_peak_guard
    import tgpg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tgpg_in_if.sink               i_in,
    tgpg_out_if.source            o_out
);

    t_top_state r_state, n_state;

    logic                    r_trem_enable;
    logic [TREM_DEPTH_W-1:0] r_trem_depth;
    logic [PHASE_STEP_W-1:0] r_phase_step;
    logic [OUT_GAIN_W-1:0]   r_out_gain;
    logic [PEAK_LIMIT_W-1:0] r_peak_limit;

    logic [PHASE_W-1:0]            r_phase;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic                          r_eob;
    logic                          r_mute;
    logic [Q15_W-1:0]              r_gain;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_left;
    logic [SAMPLE_BITS-1:0] r_out_right;
    logic                   r_out_muted;

    logic                   w_accept;
    logic                   w_alarm;
    logic                   w_mute_now;
    logic                   w_trem_act;
    logic [Q15_W-1:0]       w_depth_lim;
    logic                   w_lfo_start;
    logic                   w_lfo_done;
    logic [Q15_W-1:0]       w_lfo_gain;
    logic                   w_out_free;
    logic                   w_commit;
    t_lane_ctrl             w_lane_ctrl;
    t_merge_cmd             w_merge_cmd;
    logic [SAMPLE_BITS-1:0] w_lane_l;
    logic [SAMPLE_BITS-1:0] w_lane_r;
    logic [SAMPLE_BITS-1:0] w_mag_l;
    logic [SAMPLE_BITS-1:0] w_mag_r;

    assign i_in.ready  = (r_state == T_IDLE);
    assign w_accept    = i_in.valid && (r_state == T_IDLE);
    assign w_mute_now  = w_alarm && !i_in.clear_alarm;
    assign w_trem_act  = r_trem_enable && (r_trem_depth != '0);
    assign w_depth_lim = (r_trem_depth > Q15_ONE) ? Q15_ONE : r_trem_depth;
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign w_merge_cmd.clear  = w_accept && i_in.clear_alarm;
    assign w_merge_cmd.commit = w_commit;
    assign w_merge_cmd.mute   = r_mute;
    assign w_merge_cmd.eob    = r_eob;

    always_comb begin
        n_state     = r_state;
        w_lfo_start = 1'b0;
        w_lane_ctrl = '0;
        w_commit    = 1'b0;
        case (r_state)
            T_IDLE: begin
                if (w_accept) begin
                    if (w_mute_now) begin
                        n_state = T_DONE;
                    end else if (w_trem_act) begin
                        n_state     = T_LFO;
                        w_lfo_start = 1'b1;
                    end else begin
                        n_state = T_MUL1;
                    end
                end
            end
            T_LFO: begin
                if (w_lfo_done) n_state = T_MUL1;
            end
            T_MUL1: begin
                w_lane_ctrl.stage1_en = 1'b1;
                n_state               = T_MUL2;
            end
            T_MUL2: begin
                w_lane_ctrl.stage2_en = 1'b1;
                n_state               = T_DONE;
            end
            T_DONE: begin
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_state  = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= T_IDLE;
            r_trem_enable <= 1'b0;
            r_trem_depth  <= TREM_DEPTH_RST;
            r_phase_step  <= PHASE_STEP_RST;
            r_out_gain    <= OUT_GAIN_RST;
            r_peak_limit  <= PEAK_LIMIT_RST;
            r_phase       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_TREM_ENABLE: r_trem_enable <= i_cfg_data[0];
                    CFG_TREM_DEPTH:  r_trem_depth  <= i_cfg_data[TREM_DEPTH_W-1:0];
                    CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data[PHASE_STEP_W-1:0];
                    CFG_OUT_GAIN:    r_out_gain    <= i_cfg_data[OUT_GAIN_W-1:0];
                    CFG_PEAK_LIMIT:  r_peak_limit  <= i_cfg_data[PEAK_LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_commit && !r_mute && w_trem_act) begin
                r_phase <= r_phase + PHASE_W'(r_phase_step);
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left  <= i_in.left_in;
            r_right <= i_in.right_in;
            r_eob   <= i_in.end_of_block;
            r_mute  <= w_mute_now;
            r_gain  <= Q15_ONE;
        end
        if (w_lfo_done) begin
            r_gain <= w_lfo_gain;
        end
        if (w_commit) begin
            r_out_left  <= r_mute ? '0 : w_lane_l;
            r_out_right <= r_mute ? '0 : w_lane_r;
            r_out_muted <= r_mute;
        end
    end

    tgpg_lfo #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_lfo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lfo_start),
        .i_phase (r_phase),
        .i_depth (w_depth_lim),
        .o_done  (w_lfo_done),
        .o_gain  (w_lfo_gain)
    );

    tgpg_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_l (
        .i_clk      (i_clk),
        .i_ctrl     (w_lane_ctrl),
        .i_sample   (r_left),
        .i_gain     (r_gain),
        .i_out_gain (r_out_gain),
        .o_sample   (w_lane_l),
        .o_mag      (w_mag_l)
    );

    tgpg_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_r (
        .i_clk      (i_clk),
        .i_ctrl     (w_lane_ctrl),
        .i_sample   (r_right),
        .i_gain     (r_gain),
        .i_out_gain (r_out_gain),
        .o_sample   (w_lane_r),
        .o_mag      (w_mag_r)
    );

    tgpg_peak_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_merge_cmd),
        .i_mag_l      (w_mag_l),
        .i_mag_r      (w_mag_r),
        .i_peak_limit (r_peak_limit),
        .o_alarm      (w_alarm)
    );

    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_left;
    assign o_out.right_out = r_out_right;
    assign o_out.muted     = r_out_muted;

    `TGPG_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept, r_state != T_IDLE, "accepted word did not start")
    `TGPG_ASSERT_NEXT(a_phase_moves_on_commit, i_clk, i_rst_n, !w_commit, $stable(r_phase), "phase moved outside a commit")
    `TGPG_ASSERT_IMPL(a_lfo_done_in_wait, i_clk, i_rst_n, w_lfo_done, r_state == T_LFO, "sine gain arrived outside the wait state")
    `TGPG_ASSERT_IMPL(a_muted_word_silent, i_clk, i_rst_n, r_out_valid && r_out_muted, r_out_left == '0 && r_out_right == '0, "muted word carries a sample")

endmodule

`default_nettype wire
